// ===== rtl/degree_bounded_spanning_tree_check_macros.svh =====
// Assertion macros shared by the checker modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DEGREE_BOUNDED_SPANNING_TREE_CHECK_MACROS_SVH
`define DEGREE_BOUNDED_SPANNING_TREE_CHECK_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define DBST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define DBST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dbst_pkg.sv =====
// Shared constants, codes and control structs of the spanning tree checker.
// Used by dbst_ctrl, dbst_datapath and the top level; depends on nothing.
package dbst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 1024;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int IDX_W        = $clog2(MAX_EDGES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int VC_W         = 7;
    localparam int LIM_W        = 6;
    localparam int DEG_W        = 7;
    localparam int WGT_W        = 16;
    localparam int COST_W       = 26;
    localparam int CFG_DATA_W   = 7;
    localparam int EDGE_W       = 2 * VTX_W + WGT_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_VTX   = 2'd1;
    localparam logic [1:0] ST_NOT_LOAD  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_DEGREE_LIMIT = 1'b1;

    localparam logic [2:0] CUR_HOLD = 3'd0;
    localparam logic [2:0] CUR_EA   = 3'd1;
    localparam logic [2:0] CUR_EB   = 3'd2;
    localparam logic [2:0] CUR_PAR  = 3'd3;
    localparam logic [2:0] CUR_ZERO = 3'd4;
    localparam logic [2:0] CUR_INC  = 3'd5;

    typedef struct packed {
        logic       latch_in;
        logic       load_write;
        logic [2:0] cur_sel;
        logic       deg_write;
        logic       save_ra;
        logic       merge;
        logic       excess_chk;
        logic       set_stat;
        logic [1:0] stat;
        logic       res_write;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       load_bad;
        logic       full;
        logic       idx_bad;
        logic       edge_bad;
        logic       self_loop;
        logic       root_found;
        logic       scan_last;
        logic       vc_zero;
        logic       out_busy;
    } sts_t;

endpackage

// ===== rtl/degree_bounded_spanning_tree_check.sv =====
// Top level of the degree-bounded spanning tree checker.
// Depends on dbst_pkg, dbst_ctrl and dbst_datapath.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    operation, edge_index, endpoint_a, endpoint_b, weight
//  out      out_valid / out_ready  status, done_res, tree_valid, total_cost
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Load, unloaded-index and unused-code items go from decode to the result state; a stale
// edge first reads the edge table. An added edge reads the table, updates the degree of
// each endpoint (once for a self-loop), then walks both endpoints up the union-find
// parents to their roots. A finish item scans the degree of each of vertex_count vertices.
// One item is in work at a time; the result register frees the input while it waits.
// Reset clears all solution state at once through per-vertex valid bits; no sweep.
module degree_bounded_spanning_tree_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [dbst_pkg::IDX_W-1:0]       edge_index,
    input  logic [dbst_pkg::VTX_W-1:0]       endpoint_a,
    input  logic [dbst_pkg::VTX_W-1:0]       endpoint_b,
    input  logic [dbst_pkg::WGT_W-1:0]       weight,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic                             done_res,
    output logic                             tree_valid,
    output logic [dbst_pkg::COST_W-1:0]      total_cost,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [dbst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dbst_pkg::cmd_t cmd;
    dbst_pkg::sts_t sts;

    dbst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dbst_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation),
        .edge_index (edge_index),
        .endpoint_a (endpoint_a),
        .endpoint_b (endpoint_b),
        .weight     (weight),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .done_res   (done_res),
        .tree_valid (tree_valid),
        .total_cost (total_cost)
    );

endmodule

// ===== rtl/dbst_datapath.sv =====
// Datapath: edge table, degree and parent memories, counters, result register.
// Depends on dbst_pkg and the assertion macro header; driven by dbst_ctrl.
`include "degree_bounded_spanning_tree_check_macros.svh"
module dbst_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dbst_pkg::cmd_t                 cmd,
    output dbst_pkg::sts_t                 sts,
    input  logic [1:0]                     operation,
    input  logic [dbst_pkg::IDX_W-1:0]     edge_index,
    input  logic [dbst_pkg::VTX_W-1:0]     endpoint_a,
    input  logic [dbst_pkg::VTX_W-1:0]     endpoint_b,
    input  logic [dbst_pkg::WGT_W-1:0]     weight,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [dbst_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic                           done_res,
    output logic                           tree_valid,
    output logic [dbst_pkg::COST_W-1:0]    total_cost
);

    logic [1:0]                   op_reg;
    logic [dbst_pkg::IDX_W-1:0]   idx_reg;
    logic [dbst_pkg::VTX_W-1:0]   a_reg;
    logic [dbst_pkg::VTX_W-1:0]   b_reg;
    logic [dbst_pkg::WGT_W-1:0]   w_reg;
    logic [1:0]                   stat_reg;
    logic                         excess_reg;

    logic [dbst_pkg::VC_W-1:0]    vc_reg;
    logic [dbst_pkg::LIM_W-1:0]   lim_reg;
    logic [dbst_pkg::CNT_W-1:0]   loaded_reg;
    logic [dbst_pkg::VC_W-1:0]    comp_reg;
    logic [dbst_pkg::CNT_W-1:0]   sol_reg;
    logic [dbst_pkg::COST_W-1:0]  cost_reg;
    logic [dbst_pkg::VTX_W-1:0]   cur_reg;
    logic [dbst_pkg::VTX_W-1:0]   cur_next;
    logic [dbst_pkg::VTX_W-1:0]   ra_reg;
    logic [dbst_pkg::MAX_VERTICES-1:0] dvld_reg;
    logic [dbst_pkg::MAX_VERTICES-1:0] pvld_reg;

    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic                         done_reg;
    logic                         tree_reg;
    logic [dbst_pkg::COST_W-1:0]  total_reg;

    logic [dbst_pkg::EDGE_W-1:0]  edge_mem [dbst_pkg::MAX_EDGES];
    logic [dbst_pkg::DEG_W-1:0]   deg_mem  [dbst_pkg::MAX_VERTICES];
    logic [dbst_pkg::VTX_W-1:0]   par_mem  [dbst_pkg::MAX_VERTICES];
    logic [dbst_pkg::EDGE_W-1:0]  edge_q;
    logic [dbst_pkg::DEG_W-1:0]   deg_q;
    logic [dbst_pkg::VTX_W-1:0]   par_q;
    logic                         dvld_q;
    logic                         pvld_q;

    logic [dbst_pkg::VTX_W-1:0]   ea;
    logic [dbst_pkg::VTX_W-1:0]   eb;
    logic [dbst_pkg::WGT_W-1:0]   ew;
    logic [dbst_pkg::VC_W-1:0]    vc_eff;
    logic [dbst_pkg::DEG_W-1:0]   deg_eff;
    logic [dbst_pkg::DEG_W-1:0]   deg_inc;
    logic [dbst_pkg::VTX_W-1:0]   par_eff;
    logic                         merge_wr;
    logic                         cfg_vc_wr;
    logic                         clear_sol;
    logic                         tree_ok;
    logic [dbst_pkg::COST_W:0]    cost_sum;

    assign cfg_ready = 1'b1;
    assign cfg_vc_wr = cfg_valid && (cfg_index == dbst_pkg::REG_VERTEX_COUNT);
    assign clear_sol = cfg_vc_wr || (cmd.res_write && (op_reg == dbst_pkg::OP_FINISH));

    assign vc_eff = (vc_reg > dbst_pkg::VC_W'(dbst_pkg::MAX_VERTICES))
                    ? dbst_pkg::VC_W'(dbst_pkg::MAX_VERTICES) : vc_reg;
    assign ea = edge_q[dbst_pkg::EDGE_W-1 -: dbst_pkg::VTX_W];
    assign eb = edge_q[dbst_pkg::WGT_W +: dbst_pkg::VTX_W];
    assign ew = edge_q[dbst_pkg::WGT_W-1:0];

    assign deg_eff  = dvld_q ? deg_q : '0;
    assign deg_inc  = (deg_eff == '1) ? deg_eff : deg_eff + 1'b1;
    assign par_eff  = pvld_q ? par_q : cur_reg;
    assign merge_wr = cmd.merge && (ra_reg != cur_reg);
    assign cost_sum = {1'b0, cost_reg} + (dbst_pkg::COST_W + 1)'(ew);

    assign tree_ok = (sol_reg != '0) && (vc_eff != '0)
                     && (sol_reg == dbst_pkg::CNT_W'(vc_eff - 1'b1))
                     && (comp_reg == dbst_pkg::VC_W'(1)) && !excess_reg;

    always_comb
    begin
        case (cmd.cur_sel)
            dbst_pkg::CUR_EA:   cur_next = ea;
            dbst_pkg::CUR_EB:   cur_next = eb;
            dbst_pkg::CUR_PAR:  cur_next = par_eff;
            dbst_pkg::CUR_ZERO: cur_next = '0;
            dbst_pkg::CUR_INC:  cur_next = cur_reg + 1'b1;
            default:            cur_next = cur_reg;
        endcase
    end

    assign sts.op         = op_reg;
    assign sts.load_bad   = ({1'b0, a_reg} >= vc_eff) || ({1'b0, b_reg} >= vc_eff);
    assign sts.full       = loaded_reg >= dbst_pkg::CNT_W'(dbst_pkg::MAX_EDGES);
    assign sts.idx_bad    = {1'b0, idx_reg} >= loaded_reg;
    assign sts.edge_bad   = ({1'b0, ea} >= vc_eff) || ({1'b0, eb} >= vc_eff);
    assign sts.self_loop  = ea == eb;
    assign sts.root_found = par_eff == cur_reg;
    assign sts.scan_last  = {1'b0, cur_reg} == (vc_eff - 1'b1);
    assign sts.vc_zero    = vc_eff == '0;
    assign sts.out_busy   = out_valid_reg;

    // Memories: registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            edge_mem[loaded_reg[dbst_pkg::IDX_W-1:0]] <= {a_reg, b_reg, w_reg};
        end
        edge_q <= edge_mem[idx_reg];
        if (cmd.deg_write)
        begin
            deg_mem[cur_reg] <= deg_inc;
        end
        if (merge_wr)
        begin
            par_mem[ra_reg] <= cur_reg;
        end
        deg_q  <= deg_mem[cur_reg];
        par_q  <= par_mem[cur_reg];
        dvld_q <= dvld_reg[cur_reg];
        pvld_q <= pvld_reg[cur_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= operation;
            idx_reg <= edge_index;
            a_reg   <= endpoint_a;
            b_reg   <= endpoint_b;
            w_reg   <= weight;
        end
        cur_reg <= cur_next;
        if (cmd.save_ra)
        begin
            ra_reg <= cur_reg;
        end
        if (cmd.res_write)
        begin
            status_reg <= stat_reg;
            done_reg   <= op_reg == dbst_pkg::OP_FINISH;
            tree_reg   <= (op_reg == dbst_pkg::OP_FINISH) && tree_ok;
            total_reg  <= (op_reg == dbst_pkg::OP_FINISH) ? cost_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= dbst_pkg::VC_W'(dbst_pkg::MAX_VERTICES);
            lim_reg       <= '1;
            loaded_reg    <= '0;
            comp_reg      <= dbst_pkg::VC_W'(dbst_pkg::MAX_VERTICES);
            sol_reg       <= '0;
            cost_reg      <= '0;
            dvld_reg      <= '0;
            pvld_reg      <= '0;
            stat_reg      <= dbst_pkg::ST_OK;
            excess_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == dbst_pkg::REG_VERTEX_COUNT))
            begin
                vc_reg <= cfg_data[dbst_pkg::VC_W-1:0];
            end
            if (cfg_valid && (cfg_index == dbst_pkg::REG_DEGREE_LIMIT))
            begin
                lim_reg <= cfg_data[dbst_pkg::LIM_W-1:0];
            end
            if (cmd.load_write)
            begin
                loaded_reg <= loaded_reg + 1'b1;
            end
            if (cmd.latch_in)
            begin
                stat_reg   <= dbst_pkg::ST_OK;
                excess_reg <= 1'b0;
            end
            if (cmd.set_stat)
            begin
                stat_reg <= cmd.stat;
            end
            if (cmd.excess_chk && (deg_eff > {1'b0, lim_reg}))
            begin
                excess_reg <= 1'b1;
            end
            if (cmd.deg_write)
            begin
                dvld_reg[cur_reg] <= 1'b1;
            end
            if (merge_wr)
            begin
                pvld_reg[ra_reg] <= 1'b1;
                if (comp_reg != '0)
                begin
                    comp_reg <= comp_reg - 1'b1;
                end
            end
            if (cmd.merge)
            begin
                cost_reg <= cost_sum[dbst_pkg::COST_W] ? '1 : cost_sum[dbst_pkg::COST_W-1:0];
                if (sol_reg != '1)
                begin
                    sol_reg <= sol_reg + 1'b1;
                end
            end
            if (clear_sol)
            begin
                dvld_reg <= '0;
                pvld_reg <= '0;
                sol_reg  <= '0;
                cost_reg <= '0;
                comp_reg <= cfg_vc_wr ? ((cfg_data > dbst_pkg::VC_W'(dbst_pkg::MAX_VERTICES))
                            ? dbst_pkg::VC_W'(dbst_pkg::MAX_VERTICES)
                            : cfg_data[dbst_pkg::VC_W-1:0]) : vc_eff;
            end
            if (cmd.res_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign done_res   = done_reg;
    assign tree_valid = tree_reg;
    assign total_cost = total_reg;

    `DBST_ASSERT_SAME(a_no_overwrite, cmd.res_write, !out_valid_reg, "result register overwritten")
    `DBST_ASSERT_SAME(a_loaded_bound, 1'b1, loaded_reg <= dbst_pkg::CNT_W'(dbst_pkg::MAX_EDGES),
        "loaded edge count past table size")
    `DBST_ASSERT_NEXT(a_load_only_room, cmd.load_write,
        loaded_reg == $past(loaded_reg) + 1'b1, "edge load did not advance count")

endmodule

// ===== rtl/dbst_ctrl.sv =====
// Controller: sequences loads, solution edges, root walks and the finish scan.
// Depends on dbst_pkg and the assertion macro header; drives dbst_datapath.
`include "degree_bounded_spanning_tree_check_macros.svh"
module dbst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dbst_pkg::sts_t sts,
    output dbst_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_TBL     = 4'd2;
    localparam logic [3:0] S_DA_WAIT = 4'd3;
    localparam logic [3:0] S_DA_UPD  = 4'd4;
    localparam logic [3:0] S_DB_WAIT = 4'd5;
    localparam logic [3:0] S_DB_UPD  = 4'd6;
    localparam logic [3:0] S_FA_WAIT = 4'd7;
    localparam logic [3:0] S_FA_CHK  = 4'd8;
    localparam logic [3:0] S_FB_WAIT = 4'd9;
    localparam logic [3:0] S_FB_CHK  = 4'd10;
    localparam logic [3:0] S_SC_WAIT = 4'd11;
    localparam logic [3:0] S_SC_CHK  = 4'd12;
    localparam logic [3:0] S_RESULT  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        cmd.cur_sel = dbst_pkg::CUR_HOLD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESULT;
                case (sts.op)
                    dbst_pkg::OP_LOAD:
                    begin
                        cmd.set_stat = sts.load_bad || sts.full;
                        cmd.stat     = sts.load_bad ? dbst_pkg::ST_BAD_VTX : dbst_pkg::ST_FULL;
                        cmd.load_write = !sts.load_bad && !sts.full;
                    end
                    dbst_pkg::OP_ADD:
                    begin
                        if (sts.idx_bad)
                        begin
                            cmd.set_stat = 1'b1;
                            cmd.stat     = dbst_pkg::ST_NOT_LOAD;
                        end
                        else
                        begin
                            state_next = S_TBL;
                        end
                    end
                    dbst_pkg::OP_FINISH:
                    begin
                        cmd.cur_sel = dbst_pkg::CUR_ZERO;
                        if (!sts.vc_zero)
                        begin
                            state_next = S_SC_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_TBL:
            begin
                if (sts.edge_bad)
                begin
                    cmd.set_stat = 1'b1;
                    cmd.stat     = dbst_pkg::ST_BAD_VTX;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.cur_sel = dbst_pkg::CUR_EA;
                    state_next  = S_DA_WAIT;
                end
            end
            S_DA_WAIT: state_next = S_DA_UPD;
            S_DA_UPD:
            begin
                cmd.deg_write = 1'b1;
                if (sts.self_loop)
                begin
                    state_next = S_FA_WAIT;
                end
                else
                begin
                    cmd.cur_sel = dbst_pkg::CUR_EB;
                    state_next  = S_DB_WAIT;
                end
            end
            S_DB_WAIT: state_next = S_DB_UPD;
            S_DB_UPD:
            begin
                cmd.deg_write = 1'b1;
                cmd.cur_sel   = dbst_pkg::CUR_EA;
                state_next    = S_FA_WAIT;
            end
            S_FA_WAIT: state_next = S_FA_CHK;
            S_FA_CHK:
            begin
                if (sts.root_found)
                begin
                    cmd.save_ra = 1'b1;
                    cmd.cur_sel = dbst_pkg::CUR_EB;
                    state_next  = S_FB_WAIT;
                end
                else
                begin
                    cmd.cur_sel = dbst_pkg::CUR_PAR;
                    state_next  = S_FA_WAIT;
                end
            end
            S_FB_WAIT: state_next = S_FB_CHK;
            S_FB_CHK:
            begin
                if (sts.root_found)
                begin
                    cmd.merge  = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.cur_sel = dbst_pkg::CUR_PAR;
                    state_next  = S_FB_WAIT;
                end
            end
            S_SC_WAIT: state_next = S_SC_CHK;
            S_SC_CHK:
            begin
                cmd.excess_chk = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.cur_sel = dbst_pkg::CUR_INC;
                    state_next  = S_SC_WAIT;
                end
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DBST_ASSERT_NEXT(a_merge_then_result, cmd.merge, state_reg == S_RESULT,
        "merge not followed by result")
    `DBST_ASSERT_SAME(a_write_needs_room, cmd.load_write, !sts.full && !sts.load_bad,
        "edge stored into full table or with bad vertex")
    `DBST_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_reg == S_DECODE,
        "accepted item not decoded")

endmodule
